@@ rtl/ucb_pkg.sv @@
`timescale 1ns / 1ps
package ucb_pkg;

   localparam int MAX_KIDS = 256;
   localparam int KID_CNT_W = $clog2(MAX_KIDS + 1);

   localparam int REQ_DATA_W = 104;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [1:0] OP_VISITS = 2'd0;
   localparam logic [1:0] OP_MEAN   = 2'd1;
   localparam logic [1:0] OP_BOUND  = 2'd2;
   localparam logic [1:0] OP_PRIOR  = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] REG_EXPLORATION_GAIN    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LOSS_WEIGHT         = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_UNEXPANDED_VALUE    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LOG_TERM_GAIN       = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SCALE_BY_PARENT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_MULTI_SEARCHER      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_EXPANDED_VISITS = 3'd6;

   localparam logic [15:0] LN2_Q16 = 16'd45426;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   localparam logic [5:0] DIV_STEPS  = 6'd49;
   localparam logic [5:0] SQRT_STEPS = 6'd24;
   localparam logic [3:0] LOG_LAST   = 4'd15;

endpackage

@@ rtl/ucb_child_select_unit.sv @@
`timescale 1ns / 1ps
// Scores the child edges of one tree node, one child per input beat, and returns the index
// and Q16.16 score of the best child on the beat marked with tlast, the earliest child winning
// ties. A child scored by visits, mean or prior goes straight to the update state;
// a child scored by the confidence bound is worked by the one shift-subtract unit, which in
// turn works two square roots (24 steps each) and two divisions (49 steps each), and by the 16
// squaring passes of the logarithm through the one 32 by 32 multiplier. The input is not
// ready while a child is being scored. A finished result waits in the output register while
// the next node streams in.
module ucb_child_select_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // child_visits[15:0], reward_sum[47:16], child_prior[64:48], mean_reward[81:65],
   // parent_visits[97:82], zero fill above.
   input  logic [ucb_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation[1:0].
   input  logic [ucb_pkg::REQ_USER_W-1:0]   req_tuser,
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // best_child_index[7:0], best_score[39:8].
   output logic [ucb_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [ucb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ucb_pkg::CSR_DATA_W-1:0]   csr_wr_data
);
   import ucb_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_SQP   = 5'd1;
   localparam logic [4:0] S_WSQP  = 5'd2;
   localparam logic [4:0] S_MULC  = 5'd3;
   localparam logic [4:0] S_P1    = 5'd4;
   localparam logic [4:0] S_P2    = 5'd5;
   localparam logic [4:0] S_DIVE  = 5'd6;
   localparam logic [4:0] S_WDIVE = 5'd7;
   localparam logic [4:0] S_LOG0  = 5'd8;
   localparam logic [4:0] S_LOGM  = 5'd9;
   localparam logic [4:0] S_LOGU  = 5'd10;
   localparam logic [4:0] S_LN    = 5'd11;
   localparam logic [4:0] S_DIVR  = 5'd12;
   localparam logic [4:0] S_WDIVR = 5'd13;
   localparam logic [4:0] S_WSQR  = 5'd14;
   localparam logic [4:0] S_SUM   = 5'd15;
   localparam logic [4:0] S_UPD   = 5'd16;

   logic [23:0] gain_ff, gain_in;
   logic [16:0] lw_ff, lw_in;
   logic [16:0] unexp_ff, unexp_in;
   logic [23:0] lgain_ff, lgain_in;
   logic        scale_ff, scale_in;
   logic        multi_ff, multi_in;
   logic [15:0] minexp_ff, minexp_in;

   logic [4:0]  state_ff, state_in;
   logic [15:0] visits_ff, visits_in;
   logic [31:0] rsum_ff, rsum_in;
   logic [16:0] prior_ff, prior_in;
   logic [16:0] mean_ff, mean_in;
   logic [15:0] parent_ff, parent_in;
   logic        last_ff, last_in;
   logic        skip_ff, skip_in;
   logic [31:0] score_ff, score_in;

   logic [31:0] best_ff, best_in;
   logic [7:0]  idx_ff, idx_in;
   logic        have_ff, have_in;
   logic [KID_CNT_W-1:0] kids_ff, kids_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [63:0] prod_ff, prod_in;
   logic [31:0] mul_a, mul_b;
   logic        mul_en;
   logic [31:0] c_ff, c_in;
   logic [48:0] acc_ff, acc_in;
   logic [32:0] d_ff, d_in;
   logic [48:0] e_ff, e_in;
   logic [31:0] m_ff, m_in;
   logic [3:0]  n_ff, n_in;
   logic [15:0] frac_ff, frac_in;
   logic [3:0]  it_ff, it_in;

   logic [5:0]  u_cnt_ff, u_cnt_in;
   logic        u_sqrt_ff, u_sqrt_in;
   logic [63:0] u_src_ff, u_src_in;
   logic [33:0] u_rem_ff, u_rem_in;
   logic [33:0] u_div_ff, u_div_in;
   logic [48:0] u_q_ff, u_q_in;
   logic [34:0] u_cand, u_sub;
   logic [35:0] u_diff;
   logic        u_ok;

   logic [15:0] p_visits, p_parent;
   logic [31:0] p_rsum;
   logic [16:0] p_prior, p_mean;
   logic [31:0] vq, losses;
   logic [16:0] wc, wrest;
   logic [3:0]  lead;
   logic        expanded;
   logic [49:0] total;
   logic [31:0] mm;
   logic        better;
   logic        can_emit;

   assign p_visits = req_tdata[15:0];
   assign p_rsum   = req_tdata[47:16];
   assign p_prior  = req_tdata[64:48];
   assign p_mean   = req_tdata[81:65];
   assign p_parent = req_tdata[97:82];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign vq     = {visits_ff, 16'd0};
   assign losses = (vq > rsum_ff) ? (vq - rsum_ff) : 32'd0;
   assign wc     = (lw_ff > ONE_Q16) ? ONE_Q16 : lw_ff;
   assign wrest  = ONE_Q16 - wc;
   assign expanded = multi_ff ? (visits_ff > minexp_ff) : (visits_ff != 16'd0);
   assign mm     = prod_ff[61:30];
   assign can_emit = !rsp_valid_ff || rsp_tready;

   always_comb begin
      lead = 4'd0;
      for (int i = 1; i < 16; i++) begin
         if (parent_ff[i]) begin
            lead = 4'(i);
         end
      end
   end

   always_comb begin
      if (u_sqrt_ff) begin
         u_cand = {u_rem_ff[32:0], u_src_ff[63:62]};
         u_sub  = {u_q_ff[32:0], 2'b01};
      end else begin
         u_cand = {u_rem_ff, u_src_ff[63]};
         u_sub  = {1'b0, u_div_ff};
      end
      u_diff = {1'b0, u_cand} - {1'b0, u_sub};
      u_ok   = !u_diff[35];
   end

   always_comb begin
      total = {33'd0, (expanded ? mean_ff : unexp_ff)} + {1'b0, e_ff}
            + {18'd0, prod_ff[47:16]};
   end

   always_comb begin
      better = !skip_ff && (!have_ff || (score_ff > best_ff));
   end

   always_comb begin
      mul_en = 1'b1;
      mul_a  = 32'd0;
      mul_b  = 32'd0;
      case (state_ff)
         S_WSQP: begin
            mul_a = {8'd0, gain_ff};
            mul_b = {8'd0, u_q_ff[23:0]};
         end
         S_MULC: begin
            mul_a = losses;
            mul_b = {15'd0, wc};
         end
         S_P1: begin
            mul_a = vq;
            mul_b = {15'd0, wrest};
         end
         S_P2: begin
            mul_a = c_ff;
            mul_b = {15'd0, prior_ff};
         end
         S_LOGM: begin
            mul_a = m_ff;
            mul_b = m_ff;
         end
         S_LN: begin
            mul_a = {12'd0, n_ff, frac_ff};
            mul_b = {16'd0, LN2_Q16};
         end
         S_WSQR: begin
            mul_a = {8'd0, lgain_ff};
            mul_b = {14'd0, u_q_ff[17:0]};
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
      prod_in = mul_en ? (64'(mul_a) * 64'(mul_b)) : prod_ff;
   end

   always_comb begin
      gain_in   = gain_ff;
      lw_in     = lw_ff;
      unexp_in  = unexp_ff;
      lgain_in  = lgain_ff;
      scale_in  = scale_ff;
      multi_in  = multi_ff;
      minexp_in = minexp_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_EXPLORATION_GAIN:    gain_in   = csr_wr_data;
            REG_LOSS_WEIGHT:         lw_in     = csr_wr_data[16:0];
            REG_UNEXPANDED_VALUE:    unexp_in  = csr_wr_data[16:0];
            REG_LOG_TERM_GAIN:       lgain_in  = csr_wr_data;
            REG_SCALE_BY_PARENT:     scale_in  = csr_wr_data[0];
            REG_MULTI_SEARCHER:      multi_in  = csr_wr_data[0];
            REG_MIN_EXPANDED_VISITS: minexp_in = csr_wr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      visits_in = visits_ff;
      rsum_in   = rsum_ff;
      prior_in  = prior_ff;
      mean_in   = mean_ff;
      parent_in = parent_ff;
      last_in   = last_ff;
      skip_in   = skip_ff;
      score_in  = score_ff;
      best_in   = best_ff;
      idx_in    = idx_ff;
      have_in   = have_ff;
      kids_in   = kids_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      c_in      = c_ff;
      acc_in    = acc_ff;
      d_in      = d_ff;
      e_in      = e_ff;
      m_in      = m_ff;
      n_in      = n_ff;
      frac_in   = frac_ff;
      it_in     = it_ff;
      u_cnt_in  = u_cnt_ff;
      u_sqrt_in = u_sqrt_ff;
      u_src_in  = u_src_ff;
      u_rem_in  = u_rem_ff;
      u_div_in  = u_div_ff;
      u_q_in    = u_q_ff;

      if (u_cnt_ff != 6'd0) begin
         u_rem_in = u_ok ? u_diff[33:0] : u_cand[33:0];
         u_q_in   = {u_q_ff[47:0], u_ok};
         u_src_in = u_sqrt_ff ? {u_src_ff[61:0], 2'b00} : {u_src_ff[62:0], 1'b0};
         u_cnt_in = u_cnt_ff - 6'd1;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               visits_in = p_visits;
               rsum_in   = p_rsum;
               prior_in  = p_prior;
               mean_in   = p_mean;
               parent_in = (p_parent == 16'd0) ? 16'd1 : p_parent;
               last_in   = req_tlast;
               skip_in   = (kids_ff >= KID_CNT_W'(MAX_KIDS));
               state_in  = S_UPD;
               case (req_tuser)
                  OP_VISITS: score_in = {p_visits, 16'd0};
                  OP_MEAN:   score_in = {15'd0, p_mean};
                  OP_PRIOR:  score_in = {15'd0, p_prior};
                  OP_BOUND: begin
                     if (kids_ff < KID_CNT_W'(MAX_KIDS)) begin
                        state_in = S_SQP;
                     end
                  end
                  default: score_in = 32'd0;
               endcase
            end
         end
         S_SQP: begin
            u_sqrt_in = 1'b1;
            u_src_in  = {parent_ff, 48'd0};
            u_rem_in  = 34'd0;
            u_q_in    = 49'd0;
            u_cnt_in  = SQRT_STEPS;
            state_in  = S_WSQP;
         end
         S_WSQP: begin
            if (u_cnt_ff == 6'd0) begin
               state_in = S_MULC;
            end
         end
         S_MULC: begin
            c_in     = scale_ff ? prod_ff[47:16] : {8'd0, gain_ff};
            state_in = S_P1;
         end
         S_P1: begin
            acc_in   = prod_ff[48:0];
            state_in = S_P2;
         end
         S_P2: begin
            d_in     = 33'((acc_ff + prod_ff[48:0]) >> 16);
            state_in = S_DIVE;
         end
         S_DIVE: begin
            u_sqrt_in = 1'b0;
            u_src_in  = {prod_ff[48:0], 15'd0};
            u_div_in  = {1'b0, d_ff} + 34'd65536;
            u_rem_in  = 34'd0;
            u_q_in    = 49'd0;
            u_cnt_in  = DIV_STEPS;
            state_in  = S_WDIVE;
         end
         S_WDIVE: begin
            if (u_cnt_ff == 6'd0) begin
               e_in     = u_q_ff;
               state_in = S_LOG0;
            end
         end
         S_LOG0: begin
            n_in     = lead;
            m_in     = {16'd0, parent_ff} << (5'd30 - {1'b0, lead});
            frac_in  = 16'd0;
            it_in    = 4'd0;
            state_in = S_LOGM;
         end
         S_LOGM: begin
            state_in = S_LOGU;
         end
         S_LOGU: begin
            m_in    = mm[31] ? {1'b0, mm[31:1]} : mm;
            frac_in = {frac_ff[14:0], mm[31]};
            it_in   = it_ff + 4'd1;
            state_in = (it_ff == LOG_LAST) ? S_LN : S_LOGM;
         end
         S_LN: begin
            state_in = S_DIVR;
         end
         S_DIVR: begin
            u_sqrt_in = 1'b0;
            u_src_in  = {29'd0, prod_ff[35:16], 15'd0};
            u_div_in  = {17'd0, 17'({1'b0, visits_ff} + 17'd1)};
            u_rem_in  = 34'd0;
            u_q_in    = 49'd0;
            u_cnt_in  = DIV_STEPS;
            state_in  = S_WDIVR;
         end
         S_WDIVR: begin
            if (u_cnt_ff == 6'd0) begin
               u_sqrt_in = 1'b1;
               u_src_in  = {12'd0, u_q_ff[19:0], 32'd0};
               u_rem_in  = 34'd0;
               u_q_in    = 49'd0;
               u_cnt_in  = SQRT_STEPS;
               state_in  = S_WSQR;
            end
         end
         S_WSQR: begin
            if (u_cnt_ff == 6'd0) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            score_in = (total > 50'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
            state_in = S_UPD;
         end
         S_UPD: begin
            if (!last_ff || can_emit) begin
               state_in = S_IDLE;
               if (better) begin
                  best_in = score_ff;
                  idx_in  = 8'(kids_ff);
                  have_in = 1'b1;
               end
               if (!skip_ff) begin
                  kids_in = kids_ff + KID_CNT_W'(1);
               end
               if (last_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = better ? {score_ff, 8'(kids_ff)} : {best_ff, idx_ff};
                  best_in = 32'd0;
                  idx_in  = 8'd0;
                  have_in = 1'b0;
                  kids_in = '0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff      <= 24'd65536;
         lw_ff        <= 17'd65536;
         unexp_ff     <= 17'd65536;
         lgain_ff     <= 24'd0;
         scale_ff     <= 1'b1;
         multi_ff     <= 1'b0;
         minexp_ff    <= 16'd0;
         state_ff     <= S_IDLE;
         best_ff      <= 32'd0;
         idx_ff       <= 8'd0;
         have_ff      <= 1'b0;
         kids_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         u_cnt_ff     <= 6'd0;
         it_ff        <= 4'd0;
      end else begin
         gain_ff      <= gain_in;
         lw_ff        <= lw_in;
         unexp_ff     <= unexp_in;
         lgain_ff     <= lgain_in;
         scale_ff     <= scale_in;
         multi_ff     <= multi_in;
         minexp_ff    <= minexp_in;
         state_ff     <= state_in;
         best_ff      <= best_in;
         idx_ff       <= idx_in;
         have_ff      <= have_in;
         kids_ff      <= kids_in;
         rsp_valid_ff <= rsp_valid_in;
         u_cnt_ff     <= u_cnt_in;
         it_ff        <= it_in;
      end
   end

   always_ff @(posedge clock) begin
      visits_ff   <= visits_in;
      rsum_ff     <= rsum_in;
      prior_ff    <= prior_in;
      mean_ff     <= mean_in;
      parent_ff   <= parent_in;
      last_ff     <= last_in;
      skip_ff     <= skip_in;
      score_ff    <= score_in;
      rsp_data_ff <= rsp_data_in;
      prod_ff     <= prod_in;
      c_ff        <= c_in;
      acc_ff      <= acc_in;
      d_ff        <= d_in;
      e_ff        <= e_in;
      m_ff        <= m_in;
      n_ff        <= n_in;
      frac_ff     <= frac_in;
      u_sqrt_ff   <= u_sqrt_in;
      u_src_ff    <= u_src_in;
      u_rem_ff    <= u_rem_in;
      u_div_ff    <= u_div_in;
      u_q_ff      <= u_q_in;
   end

`ifndef SYNTH
   // The shared unit only steps while the sequencer waits on it.
   a_unit_busy: assert property (@(posedge clock) disable iff (reset)
      (u_cnt_ff != 6'd0) |-> (state_ff == S_WSQP || state_ff == S_WDIVE ||
                              state_ff == S_WDIVR || state_ff == S_WSQR))
      else $error("shift-subtract unit busy outside a wait state");

   a_kids_cap: assert property (@(posedge clock) disable iff (reset)
      kids_ff <= KID_CNT_W'(MAX_KIDS))
      else $error("child count beyond its limit");

   // Closing a node clears the running maximum and raises the result.
   a_node_close: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && last_ff && can_emit) |=>
         (!have_ff && kids_ff == '0 && rsp_valid_ff && state_ff == S_IDLE))
      else $error("node close did not clear state");

   a_have_kids: assert property (@(posedge clock) disable iff (reset)
      have_ff |-> (kids_ff != '0))
      else $error("candidate held with no child counted");
`endif

endmodule
